>>> hw/rtl/assert_macros.svh
// Assertion macros shared by the set membership table RTL.
// Depends on nothing; included by the modules that carry checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property holds at every edge outside reset.
`define SMT_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define SMT_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Antecedent implies consequent in the following cycle.
`define SMT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> hw/rtl/smt_pkg.sv
// Package for the set membership table: beat types, command codes, probe token.
// Depends on nothing; used by smt_cell and set_membership_table_top.
package smt_pkg;

	localparam int Capacity  = 64;
	localparam int ValueBits = 32;

	localparam int CmdBits       = 2;
	localparam int ReqValueBits  = 32;
	localparam int RespCountBits = 7;

	localparam logic [CmdBits-1:0] CmdAdd    = 2'd0;
	localparam logic [CmdBits-1:0] CmdRemove = 2'd1;
	localparam logic [CmdBits-1:0] CmdQuery  = 2'd2;

	typedef struct packed {
		logic [CmdBits-1:0]             cmd;
		logic signed [ReqValueBits-1:0] value;
	} req_t;

	typedef struct packed {
		logic                     success;
		logic                     full_rejected;
		logic [RespCountBits-1:0] count;
		logic                     is_empty;
	} resp_t;

	// Token handed from cell to cell during a scan.
	typedef struct packed {
		logic active;
		logic hit;   // a valid entry matching the key lies upstream
		logic free;  // an invalid entry lies upstream
	} probe_t;

	// Broadcast from the controller to every cell at the end of a scan.
	typedef struct packed {
		logic add;
		logic remove;
	} commit_t;

endpackage

>>> hw/rtl/smt_cell.sv
// One table entry of the set membership table: value, valid bit, scan flags.
// Depends on smt_pkg and assert_macros.svh.
`include "assert_macros.svh"

module smt_cell #(
	parameter int VALUE_BITS = smt_pkg::ValueBits
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [VALUE_BITS-1:0] key,
	input  smt_pkg::probe_t       probe_in,
	input  smt_pkg::commit_t      commit,
	output smt_pkg::probe_t       probe_out
);
	import smt_pkg::*;

	logic [VALUE_BITS-1:0] value_q;
	logic                  valid_q;
	logic                  match_q;
	logic                  cand_q;
	probe_t                probe_q;

	logic match_now;

	assign match_now = valid_q && (value_q == key);
	assign probe_out = probe_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			match_q <= 1'b0;
			cand_q  <= 1'b0;
			probe_q <= '0;
		end else begin
			probe_q.active <= probe_in.active;
			if (probe_in.active) begin
				match_q      <= match_now;
				// lowest free entry: free here and nothing free upstream
				cand_q       <= !valid_q && !probe_in.free;
				probe_q.hit  <= probe_in.hit || match_now;
				probe_q.free <= probe_in.free || !valid_q;
			end
			if (commit.add && cand_q) begin
				valid_q <= 1'b1;
			end else if (commit.remove && match_q) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (commit.add && cand_q) begin
			value_q <= key;
		end
	end

	`SMT_ASSERT(a_cand_match_excl, clk, arst_n, !(cand_q && match_q), "cell both candidate and match")
	`SMT_ASSERT_IMP(a_add_into_free, clk, arst_n, commit.add && cand_q, !valid_q, "add into an occupied cell")
	`SMT_ASSERT_IMP(a_remove_valid, clk, arst_n, commit.remove && match_q, valid_q, "remove from an empty cell")

endmodule

>>> hw/rtl/set_membership_table_top.sv
// Each request (add, remove or query of one value) is answered by one response beat.
// After acceptance a request goes through these steps before the next request can be
// accepted: a register launches a probe token, the token walks the row of CAPACITY
// entry cells one cell per cycle, the scan outcome is latched, then the change is
// committed and the response register loaded. req_stall is high while a
// request is in flight; a response waiting on rsp_stall does not block acceptance,
// but the following request holds at its commit until the output frees.
// Values compare on their low VALUE_BITS bits. Adding a value not yet present to a full table sets full_rejected.
// Depends on smt_pkg, smt_cell and assert_macros.svh.
`include "assert_macros.svh"

module set_membership_table_top #(
	parameter int CAPACITY   = smt_pkg::Capacity,
	parameter int VALUE_BITS = smt_pkg::ValueBits
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  smt_pkg::req_t  req,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output smt_pkg::resp_t rsp
);
	import smt_pkg::*;

	localparam int CntBits = $clog2(CAPACITY + 1);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_SCAN = 3'b010,
		ST_DONE = 3'b100
	} state_t;

	state_t                state_q;
	logic [CmdBits-1:0]    cmd_q;
	logic [VALUE_BITS-1:0] key_q;
	logic                  launch_q;
	logic                  hit_q;
	logic                  free_q;
	logic [CntBits-1:0]    count_q;
	logic                  rsp_valid_q;
	resp_t                 rsp_q;

	probe_t  probe [CAPACITY+1];
	commit_t commit;

	logic               accept;
	logic               out_free;
	logic               fire;
	logic               success;
	logic               full;
	logic [CntBits-1:0] count_next;

	assign req_stall = (state_q != ST_IDLE);
	assign accept    = req_valid && !req_stall;
	assign out_free  = !rsp_valid_q || !rsp_stall;
	assign fire      = (state_q == ST_DONE) && out_free;

	assign probe[0] = '{active: launch_q, hit: 1'b0, free: 1'b0};

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		smt_cell #(
			.VALUE_BITS(VALUE_BITS)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.key      (key_q),
			.probe_in (probe[i]),
			.commit   (commit),
			.probe_out(probe[i+1])
		);
	end

	assign commit.add    = fire && (cmd_q == CmdAdd) && !hit_q && free_q;
	assign commit.remove = fire && (cmd_q == CmdRemove) && hit_q;

	always_comb begin
		success    = 1'b0;
		full       = 1'b0;
		count_next = count_q;
		case (cmd_q)
			CmdAdd: begin
				success = !hit_q && free_q;
				full    = !hit_q && !free_q;
				if (!hit_q && free_q) begin
					count_next = count_q + CntBits'(1);
				end
			end
			CmdRemove: begin
				success = hit_q;
				if (hit_q) begin
					count_next = count_q - CntBits'(1);
				end
			end
			CmdQuery: begin
				success = hit_q;
			end
			default: begin
				success = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			launch_q    <= 1'b0;
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			launch_q <= accept;
			if (fire) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (probe[CAPACITY].active) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					// hold until the response register is free
					if (out_free) begin
						count_q <= count_next;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q <= req.cmd;
			key_q <= VALUE_BITS'($unsigned(req.value));
		end
		if (probe[CAPACITY].active) begin
			hit_q  <= probe[CAPACITY].hit;
			free_q <= probe[CAPACITY].free;
		end
		if (fire) begin
			rsp_q.success       <= success;
			rsp_q.full_rejected <= full;
			rsp_q.count         <= RespCountBits'(count_next);
			rsp_q.is_empty      <= (count_next == '0);
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	`SMT_ASSERT(a_count_range, clk, arst_n, count_q <= CntBits'(CAPACITY),
		"element count above capacity")
	`SMT_ASSERT(a_commit_excl, clk, arst_n, !(commit.add && commit.remove),
		"add and remove committed together")
	`SMT_ASSERT_IMP(a_token_in_scan, clk, arst_n, probe[CAPACITY].active,
		state_q == ST_SCAN, "probe left the chain outside a scan")
	`SMT_ASSERT_NEXT(a_fire_to_rsp, clk, arst_n, fire,
		rsp_valid_q && (state_q == ST_IDLE), "commit did not load a response")

endmodule
